// ----- rtl/core/pixel_depth_packer_core_assert.svh -----
// assertion macros shared by the packer modules
`ifndef PIXEL_DEPTH_PACKER_CORE_ASSERT_SVH
`define PIXEL_DEPTH_PACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PDP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel depth packer: assertion failed");
`define PDP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel depth packer: assertion failed");
`else
`define PDP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PDP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/pdp_pkg.sv -----
`default_nettype none

package pdp_pkg;

  localparam int unsigned MAX_ROW_WIDTH  = 4096;
  localparam int unsigned ROW_WIDTH_BITS = 13;

  typedef logic [ROW_WIDTH_BITS-1:0] col_t;

  typedef enum logic [1:0] {
    REG_DEPTH_CODE = 2'd0,
    REG_MSB_FIRST  = 2'd1,
    REG_ROW_WIDTH  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] depth_code;
    logic       msb_first;
    col_t       width;        // already clamped to 1..MAX_ROW_WIDTH
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       first_of_image;
  } item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       row_end;
    logic       last_of_run;
  } result_t;

  function automatic logic [2:0] start_pos(logic [1:0] lg, logic msb);
    logic [3:0] d;
    d = 4'd1 << lg;
    return msb ? 3'(4'd8 - d) : 3'd0;
  endfunction

  // slots still needed (including this one) until the byte completes
  function automatic logic [3:0] slots_to_fill(logic [2:0] pos, logic [1:0] lg, logic msb);
    logic [3:0] d;
    logic [3:0] gap;
    d   = 4'd1 << lg;
    gap = 4'd8 - {1'b0, pos};
    if (msb) begin
      return ({1'b0, pos} >> lg) + 4'd1;
    end
    return (gap + d - 4'd1) >> lg;
  endfunction

  function automatic logic [3:0] full_slots(logic [1:0] lg);
    return 4'd8 >> lg;
  endfunction

  // move by r slots that do not complete the byte
  function automatic logic [2:0] pos_advance(logic [2:0] pos, logic [1:0] lg, logic msb,
                                             logic [3:0] r);
    logic [3:0] span;
    span = r << lg;
    return msb ? 3'({1'b0, pos} - span) : 3'({1'b0, pos} + span);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pdp_cfg.sv -----
`default_nettype none

module pdp_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [12:0]       cfg_data,
  output pdp_pkg::cfg_t          cfg
);
  import pdp_pkg::*;

  logic [1:0] depth_code;
  logic       msb_first;
  col_t       row_width;
  logic       wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_code <= 2'd3;
      msb_first  <= 1'b0;
      row_width  <= col_t'(1);
    end else if (wr) begin
      if (cfg_index == REG_DEPTH_CODE) begin
        depth_code <= cfg_data[1:0];
      end
      if (cfg_index == REG_MSB_FIRST) begin
        msb_first <= cfg_data[0];
      end
      if (cfg_index == REG_ROW_WIDTH) begin
        row_width <= cfg_data;
      end
    end
  end

  always_comb begin
    cfg.depth_code = depth_code;
    cfg.msb_first  = msb_first;
    if (row_width == '0) begin
      cfg.width = col_t'(1);
    end else if (row_width > col_t'(MAX_ROW_WIDTH)) begin
      cfg.width = col_t'(MAX_ROW_WIDTH);
    end else begin
      cfg.width = row_width;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pdp_inreg.sv -----
`default_nettype none

module pdp_inreg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  pdp_pkg::item_t     in_item,
  output logic               valid,
  output pdp_pkg::item_t     item,
  input  wire logic          take
);
  import pdp_pkg::*;

  // refills in the same cycle that the engine takes the held item
  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pdp_engine.sv -----
`default_nettype none

`include "pixel_depth_packer_core_assert.svh"

module pdp_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  pdp_pkg::cfg_t      cfg,
  input  wire logic          item_valid,
  input  pdp_pkg::item_t     item,
  output logic               take,
  input  wire logic          full,
  output logic               push,
  output pdp_pkg::result_t   res
);
  import pdp_pkg::*;

  logic [7:0] partial, partial_next;
  logic [2:0] pos, pos_next;
  col_t       col, col_next;
  logic [3:0] pad_left, pad_left_next;

  logic       space;
  logic [2:0] start;
  logic [3:0] nfull;
  logic [2:0] p0;
  logic [7:0] b0, b1;
  logic [15:0] shifted;
  col_t       col1;
  logic       row_done;
  logic       pix_done;
  logic [2:0] p1;
  logic [3:0] pad_cnt;
  logic [3:0] np;
  logic [3:0] rem;

  assign space = !full;
  assign take  = item_valid && (pad_left == 4'd0) && space;
  assign start = start_pos(cfg.depth_code, cfg.msb_first);
  assign nfull = full_slots(cfg.depth_code);

  // pixel slot
  always_comb begin
    p0       = item.first_of_image ? start : pos;
    b0       = item.first_of_image ? 8'd0 : partial;
    shifted  = {8'd0, item.pixel_value} << p0;
    b1       = b0 | shifted[7:0];
    pix_done = slots_to_fill(p0, cfg.depth_code, cfg.msb_first) == 4'd1;
    p1       = pix_done ? start : pos_advance(p0, cfg.depth_code, cfg.msb_first, 4'd1);
    col1     = (item.first_of_image ? col_t'(0) : col) + col_t'(1);
    row_done = col1 >= cfg.width;
    pad_cnt  = (cfg.width[2:0] == 3'd0) ? 4'd8 : 4'd8 - {1'b0, cfg.width[2:0]};
  end

  // padding: one completed byte (or the tail of the slots) per cycle while the queue has space
  assign np  = slots_to_fill(pos, cfg.depth_code, cfg.msb_first);
  assign rem = pad_left - np;

  always_comb begin
    partial_next = partial;
    pos_next     = pos;
    col_next     = col;
    pad_left_next = pad_left;
    push         = 1'b0;
    res          = '0;
    if (take) begin
      partial_next = pix_done ? 8'd0 : b1;
      pos_next     = p1;
      col_next     = row_done ? col_t'(0) : col1;
      if (row_done) begin
        pad_left_next = pad_cnt;
      end
      if (pix_done) begin
        push            = 1'b1;
        res.packed_byte = b1;
        // padding from a fresh byte emits only if it spans a whole byte
        res.last_of_run = !row_done || (pad_cnt < nfull);
      end
    end else if ((pad_left != 4'd0) && space) begin
      if (np <= pad_left) begin
        push            = 1'b1;
        res.packed_byte = partial;
        res.row_end     = (rem == 4'd0);
        res.last_of_run = (rem < nfull);
        partial_next    = 8'd0;
        pos_next        = start;
        pad_left_next   = rem;
      end else begin
        pos_next      = pos_advance(pos, cfg.depth_code, cfg.msb_first, pad_left);
        pad_left_next = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial  <= 8'd0;
      pos      <= 3'd0;
      col      <= '0;
      pad_left <= 4'd0;
    end else begin
      partial  <= partial_next;
      pos      <= pos_next;
      col      <= col_next;
      pad_left <= pad_left_next;
    end
  end

  `PDP_ASSERT_NEXT(a_pad_shrinks, clk, rst, (pad_left != 4'd0) && space, pad_left < $past(pad_left))
  `PDP_ASSERT_NEXT(a_row_end_closes_pad, clk, rst, push && res.row_end, pad_left == 4'd0)
  `PDP_ASSERT_NEXT(a_mid_row_no_pad, clk, rst, take && !row_done, pad_left == 4'd0)

endmodule

`default_nettype wire

// ----- rtl/core/pdp_outq.sv -----
`default_nettype none

`include "pixel_depth_packer_core_assert.svh"

module pdp_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  pdp_pkg::result_t   push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pdp_pkg::result_t   out_data
);
  import pdp_pkg::*;

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;
  logic       wr;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign wr        = push && !full;
  assign pop       = out_valid && out_ready;

  always_comb begin
    case ({wr, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `PDP_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count != 2'd3)
  `PDP_ASSERT_IMPL(a_no_overrun, clk, rst, push, !full)
  `PDP_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 2'd1)

endmodule

`default_nettype wire

// ----- rtl/core/pixel_depth_packer_core.sv -----
// pixel depth packer: packs 1, 2, 4 or 8 bit pixel codes into bytes
//
// s_* channel takes one pixel per transaction (tdata = pixel code, tuser =
// first pixel of an image). m_* channel gives one packed byte per transaction
// (tlast = last byte caused by that pixel, tuser = final byte of a row).
// cfg_* writes depth_code (0), msb_first (1) and row_width (2); write only
// while the block is idle. cfg_ready is always high.
//
// a pixel enters an input register, is packed by the engine once it is taken
// and lands in a two-entry output queue, whose head shows on m_tvalid. one
// pixel is taken every cycle while no padding is run and the queue has room;
// after the last pixel of a row the input is held while the padding slots are
// run, one completed byte (or the leftover slots) per cycle while there is room.
// when m_tready is low the queue absorbs up to two bytes, then the engine
// and the input stall until space frees up. nothing is lost or repeated.
//
// reset clears the queue and input register, sets depth 8 bits, lsb-first
// order, row width 1, and empties the partial byte and column count.
`default_nettype none

module pixel_depth_packer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel_value
  input  wire logic        s_tuser,   // [0] first_of_image
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] packed_byte
  output logic             m_tlast,
  output logic             m_tuser,   // [0] row_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import pdp_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    full;
  logic    push;
  result_t res;
  result_t out_data;

  assign in_item.pixel_value    = s_tdata;
  assign in_item.first_of_image = s_tuser;

  pdp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdp_inreg u_inreg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .valid    (item_valid),
    .item     (item),
    .take     (take)
  );

  pdp_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .full       (full),
    .push       (push),
    .res        (res)
  );

  pdp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data.packed_byte;
  assign m_tuser = out_data.row_end;
  assign m_tlast = out_data.last_of_run;

endmodule

`default_nettype wire
